// ===== sv/rwlc_pkg.sv =====
package rwlc_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int Q_BITS     = COORD_BITS + FRAC_BITS;
  localparam int MAX_PASSES = 16;
  localparam int PASS_BITS  = $clog2(MAX_PASSES + 1);
  localparam int DIV_CNT_BITS = $clog2(Q_BITS);
  localparam int CFG_IDX_BITS = 2;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_BITS-1:0] REG_XMIN = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_XMAX = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_YMIN = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_YMAX = 2'd3;

  // Outcode bits
  localparam logic [3:0] OC_LEFT   = 4'd1;
  localparam logic [3:0] OC_RIGHT  = 4'd2;
  localparam logic [3:0] OC_BOTTOM = 4'd4;
  localparam logic [3:0] OC_TOP    = 4'd8;

  // Window edge that a pass clips against
  localparam logic [1:0] EDGE_TOP    = 2'd0;
  localparam logic [1:0] EDGE_BOTTOM = 2'd1;
  localparam logic [1:0] EDGE_RIGHT  = 2'd2;
  localparam logic [1:0] EDGE_LEFT   = 2'd3;

  typedef struct packed {
    logic       load;       // capture a new segment
    logic       setup;      // register multiply and divide operands
    logic       mul;        // register the product
    logic       div_start;  // start the divider on the product
    logic       move;       // write the clipped point back
    logic       out_load;   // load the result register
    logic       vis;        // visible flag for out_load
    logic       sel_end;    // 0: first endpoint moves, 1: second
    logic [1:0] edge_sel;
  } cmd_t;

  typedef struct packed {
    logic [3:0] code_start;
    logic [3:0] code_end;
    logic       win_bad;
    logic       div_done;
  } status_t;

endpackage

// ===== sv/rwlc_div.sv =====
module rwlc_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [2*rwlc_pkg::Q_BITS-1:0]  dividend,
  input  logic [rwlc_pkg::Q_BITS-1:0]    divisor,
  output logic                           done,
  output logic [rwlc_pkg::Q_BITS-1:0]    quotient
);

  logic                                busy;
  logic [rwlc_pkg::DIV_CNT_BITS-1:0]   cnt;
  logic [rwlc_pkg::Q_BITS-1:0]         rem;
  logic [rwlc_pkg::Q_BITS-1:0]         low;
  logic [rwlc_pkg::Q_BITS-1:0]         dsr;
  logic [rwlc_pkg::Q_BITS:0]           trial;
  logic [rwlc_pkg::Q_BITS:0]           diff;
  logic                                qbit;

  // Upper half of the dividend stays below the divisor, so the quotient fits Q_BITS
  assign trial = {rem, low[rwlc_pkg::Q_BITS-1]};
  assign diff  = trial - {1'b0, dsr};
  assign qbit  = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == rwlc_pkg::DIV_CNT_BITS'(rwlc_pkg::Q_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[2*rwlc_pkg::Q_BITS-1:rwlc_pkg::Q_BITS];
      low <= dividend[rwlc_pkg::Q_BITS-1:0];
      dsr <= divisor;
    end else if (busy) begin
      rem <= qbit ? diff[rwlc_pkg::Q_BITS-1:0] : trial[rwlc_pkg::Q_BITS-1:0];
      low <= {low[rwlc_pkg::Q_BITS-2:0], qbit};
    end
  end

  assign quotient = low;

endmodule

// ===== sv/rwlc_datapath.sv =====
module rwlc_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  rwlc_pkg::cmd_t                        cmd,
  output rwlc_pkg::status_t                     status,
  input  logic signed [rwlc_pkg::COORD_BITS-1:0] win_xmin,
  input  logic signed [rwlc_pkg::COORD_BITS-1:0] win_xmax,
  input  logic signed [rwlc_pkg::COORD_BITS-1:0] win_ymin,
  input  logic signed [rwlc_pkg::COORD_BITS-1:0] win_ymax,
  input  logic signed [rwlc_pkg::COORD_BITS-1:0] seg_x_start,
  input  logic signed [rwlc_pkg::COORD_BITS-1:0] seg_y_start,
  input  logic signed [rwlc_pkg::COORD_BITS-1:0] seg_x_end,
  input  logic signed [rwlc_pkg::COORD_BITS-1:0] seg_y_end,
  output logic                                  visible,
  output logic signed [rwlc_pkg::COORD_BITS-1:0] clip_x_start,
  output logic signed [rwlc_pkg::COORD_BITS-1:0] clip_y_start,
  output logic signed [rwlc_pkg::COORD_BITS-1:0] clip_x_end,
  output logic signed [rwlc_pkg::COORD_BITS-1:0] clip_y_end
);

  typedef logic signed [rwlc_pkg::Q_BITS-1:0] q_t;
  typedef logic signed [rwlc_pkg::Q_BITS:0]   qx_t;

  q_t x1, y1, x2, y2;
  q_t xl, xh, yl, yh;
  q_t edge_val, edge_val_next;
  q_t base, moved;
  qx_t diff_a, diff_b, diff_d;
  logic signed [rwlc_pkg::Q_BITS+1:0] sum;
  logic [rwlc_pkg::Q_BITS-1:0]   ua, ub, ud, quot;
  logic [2*rwlc_pkg::Q_BITS-1:0] prod;
  logic neg, dzero, horiz, div_done;

  function automatic logic [3:0] outcode(input q_t x, input q_t y, input q_t xlo,
                                         input q_t xhi, input q_t ylo, input q_t yhi);
    logic [3:0] c;
    c = '0;
    if (x < xlo)      c = c | rwlc_pkg::OC_LEFT;
    else if (x > xhi) c = c | rwlc_pkg::OC_RIGHT;
    if (y < ylo)      c = c | rwlc_pkg::OC_BOTTOM;
    else if (y > yhi) c = c | rwlc_pkg::OC_TOP;
    return c;
  endfunction

  function automatic logic [rwlc_pkg::Q_BITS-1:0] magnitude(input qx_t v);
    qx_t a;
    a = v[rwlc_pkg::Q_BITS] ? -v : v;
    return a[rwlc_pkg::Q_BITS-1:0];
  endfunction

  // Truncate a fixed-point value toward zero to an integer
  function automatic logic signed [rwlc_pkg::COORD_BITS-1:0] to_int(input q_t v);
    qx_t adj;
    adj = {v[rwlc_pkg::Q_BITS-1], v}
        + (v[rwlc_pkg::Q_BITS-1] ? qx_t'((1 << rwlc_pkg::FRAC_BITS) - 1) : qx_t'(0));
    return adj[rwlc_pkg::FRAC_BITS +: rwlc_pkg::COORD_BITS];
  endfunction

  function automatic q_t to_q(input logic signed [rwlc_pkg::COORD_BITS-1:0] v);
    return {v, {rwlc_pkg::FRAC_BITS{1'b0}}};
  endfunction

  assign xl = to_q(win_xmin);
  assign xh = to_q(win_xmax);
  assign yl = to_q(win_ymin);
  assign yh = to_q(win_ymax);

  assign horiz = (cmd.edge_sel == rwlc_pkg::EDGE_TOP) ||
                 (cmd.edge_sel == rwlc_pkg::EDGE_BOTTOM);

  always_comb begin
    case (cmd.edge_sel)
      rwlc_pkg::EDGE_TOP:    edge_val_next = yh;
      rwlc_pkg::EDGE_BOTTOM: edge_val_next = yl;
      rwlc_pkg::EDGE_RIGHT:  edge_val_next = xh;
      default:               edge_val_next = xl;
    endcase
  end

  always_comb begin
    if (horiz) begin
      diff_a = qx_t'(x2) - qx_t'(x1);
      diff_b = qx_t'(edge_val_next) - qx_t'(y1);
      diff_d = qx_t'(y2) - qx_t'(y1);
    end else begin
      diff_a = qx_t'(y2) - qx_t'(y1);
      diff_b = qx_t'(edge_val_next) - qx_t'(x1);
      diff_d = qx_t'(x2) - qx_t'(x1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      ua       <= magnitude(diff_a);
      ub       <= magnitude(diff_b);
      ud       <= magnitude(diff_d);
      neg      <= diff_a[rwlc_pkg::Q_BITS] ^ diff_b[rwlc_pkg::Q_BITS] ^
                  diff_d[rwlc_pkg::Q_BITS];
      dzero    <= (diff_d == '0);
      edge_val <= edge_val_next;
    end
    if (cmd.mul) begin
      prod <= (2*rwlc_pkg::Q_BITS)'(ua) * (2*rwlc_pkg::Q_BITS)'(ub);
    end
  end

  rwlc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod),
    .divisor  (ud),
    .done     (div_done),
    .quotient (quot)
  );

  // Add the signed quotient to the first endpoint's other coordinate
  always_comb begin
    base = horiz ? x1 : y1;
    if (dzero)
      sum = {{2{base[rwlc_pkg::Q_BITS-1]}}, base};
    else if (neg)
      sum = {{2{base[rwlc_pkg::Q_BITS-1]}}, base} - {2'b00, quot};
    else
      sum = {{2{base[rwlc_pkg::Q_BITS-1]}}, base} + {2'b00, quot};
    moved = sum[rwlc_pkg::Q_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x1 <= to_q(seg_x_start);
      y1 <= to_q(seg_y_start);
      x2 <= to_q(seg_x_end);
      y2 <= to_q(seg_y_end);
    end else if (cmd.move) begin
      if (!cmd.sel_end) begin
        x1 <= horiz ? moved : edge_val;
        y1 <= horiz ? edge_val : moved;
      end else begin
        x2 <= horiz ? moved : edge_val;
        y2 <= horiz ? edge_val : moved;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      visible      <= cmd.vis;
      clip_x_start <= cmd.vis ? to_int(x1) : '0;
      clip_y_start <= cmd.vis ? to_int(y1) : '0;
      clip_x_end   <= cmd.vis ? to_int(x2) : '0;
      clip_y_end   <= cmd.vis ? to_int(y2) : '0;
    end
  end

  assign status.code_start = outcode(x1, y1, xl, xh, yl, yh);
  assign status.code_end   = outcode(x2, y2, xl, xh, yl, yh);
  assign status.win_bad    = (win_xmin > win_xmax) || (win_ymin > win_ymax);
  assign status.div_done   = div_done;

endmodule

// ===== sv/rwlc_ctrl.sv =====
module rwlc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  rwlc_pkg::status_t status,
  output rwlc_pkg::cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_DIVGO = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0] state, state_next;
  logic [rwlc_pkg::PASS_BITS-1:0] pass, pass_next;
  logic       vis, vis_next;
  logic       sel_end, sel_end_next;
  logic [1:0] edge_sel, edge_sel_next;
  logic       out_valid_next;
  logic [3:0] code;
  logic       out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);
  assign code = (status.code_start != '0) ? status.code_start : status.code_end;

  always_comb begin
    state_next     = state;
    pass_next      = pass;
    vis_next       = vis;
    sel_end_next   = sel_end;
    edge_sel_next  = edge_sel;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    cmd.vis        = vis;
    cmd.sel_end    = sel_end;
    cmd.edge_sel   = edge_sel;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          pass_next  = '0;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.win_bad) begin
          vis_next   = 1'b0;
          state_next = ST_DONE;
        end else if (status.code_start == '0 && status.code_end == '0) begin
          vis_next   = 1'b1;
          state_next = ST_DONE;
        end else if ((status.code_start & status.code_end) != '0 ||
                     pass == rwlc_pkg::PASS_BITS'(rwlc_pkg::MAX_PASSES)) begin
          vis_next   = 1'b0;
          state_next = ST_DONE;
        end else begin
          sel_end_next = (status.code_start == '0);
          if ((code & rwlc_pkg::OC_TOP) != '0)         edge_sel_next = rwlc_pkg::EDGE_TOP;
          else if ((code & rwlc_pkg::OC_BOTTOM) != '0) edge_sel_next = rwlc_pkg::EDGE_BOTTOM;
          else if ((code & rwlc_pkg::OC_RIGHT) != '0)  edge_sel_next = rwlc_pkg::EDGE_RIGHT;
          else                                         edge_sel_next = rwlc_pkg::EDGE_LEFT;
          cmd.setup    = 1'b1;
          cmd.sel_end  = sel_end_next;
          cmd.edge_sel = edge_sel_next;
          state_next   = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_DIVGO;
      end
      ST_DIVGO: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_done) begin
          cmd.move   = 1'b1;
          pass_next  = pass + 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_DONE: begin
        // Hold the result until the output register is free
        if (out_free) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pass      <= '0;
      vis       <= 1'b0;
      sel_end   <= 1'b0;
      edge_sel  <= rwlc_pkg::EDGE_TOP;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pass      <= pass_next;
      vis       <= vis_next;
      sel_end   <= sel_end_next;
      edge_sel  <= edge_sel_next;
      out_valid <= out_valid_next;
    end
  end

  a_pass_bound: assert property (@(posedge clk) disable iff (rst)
    pass <= rwlc_pkg::PASS_BITS'(rwlc_pkg::MAX_PASSES))
    else $error("pass count beyond limit");

  a_accept_to_check: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_CHECK))
    else $error("accepted segment did not enter outcode check");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> (state == ST_DIV))
    else $error("divider finished outside divide state");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result register overwritten while pending");

  a_move_needs_reject_check: assert property (@(posedge clk) disable iff (rst)
    cmd.setup |-> (!status.win_bad && (status.code_start & status.code_end) == '0))
    else $error("edge move started on a rejectable segment");

endmodule

// ===== sv/rect_window_line_clipper.sv =====
// Channel   Handshake               Payload
// cfg       cfg_valid / cfg_ready   cfg_index, cfg_data (window register write)
// in        in_valid / in_ready     seg_x_start, seg_y_start, seg_x_end, seg_y_end
// out       out_valid / out_ready   visible, clip_x_start, clip_y_start, clip_x_end, clip_y_end
//
// One segment at a time: each edge move steps through setup, one multiply, the divider start
// and a restoring divider, up to 4 moves in a proper window and 16 moves at the hard limit.
// The result register frees the input side: a new segment is taken while a result waits.
// Reset (rst, synchronous) loads the default window 0..1023 by 0..767 and empties the block.
// cfg_ready is always high; write the window only while no segment is in flight.
module rect_window_line_clipper (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [rwlc_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [rwlc_pkg::COORD_BITS-1:0]        cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [rwlc_pkg::COORD_BITS-1:0] seg_x_start,
  input  logic signed [rwlc_pkg::COORD_BITS-1:0] seg_y_start,
  input  logic signed [rwlc_pkg::COORD_BITS-1:0] seg_x_end,
  input  logic signed [rwlc_pkg::COORD_BITS-1:0] seg_y_end,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   visible,
  output logic signed [rwlc_pkg::COORD_BITS-1:0] clip_x_start,
  output logic signed [rwlc_pkg::COORD_BITS-1:0] clip_y_start,
  output logic signed [rwlc_pkg::COORD_BITS-1:0] clip_x_end,
  output logic signed [rwlc_pkg::COORD_BITS-1:0] clip_y_end
);

  logic signed [rwlc_pkg::COORD_BITS-1:0] win_xmin, win_xmax, win_ymin, win_ymax;
  rwlc_pkg::cmd_t    cmd;
  rwlc_pkg::status_t status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_xmin <= rwlc_pkg::COORD_BITS'(0);
      win_xmax <= rwlc_pkg::COORD_BITS'(1023);
      win_ymin <= rwlc_pkg::COORD_BITS'(0);
      win_ymax <= rwlc_pkg::COORD_BITS'(767);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rwlc_pkg::REG_XMIN: win_xmin <= cfg_data;
        rwlc_pkg::REG_XMAX: win_xmax <= cfg_data;
        rwlc_pkg::REG_YMIN: win_ymin <= cfg_data;
        rwlc_pkg::REG_YMAX: win_ymax <= cfg_data;
        default: ;
      endcase
    end
  end

  rwlc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  rwlc_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .win_xmin     (win_xmin),
    .win_xmax     (win_xmax),
    .win_ymin     (win_ymin),
    .win_ymax     (win_ymax),
    .seg_x_start  (seg_x_start),
    .seg_y_start  (seg_y_start),
    .seg_x_end    (seg_x_end),
    .seg_y_end    (seg_y_end),
    .visible      (visible),
    .clip_x_start (clip_x_start),
    .clip_y_start (clip_y_start),
    .clip_x_end   (clip_x_end),
    .clip_y_end   (clip_y_end)
  );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int CW            = rwlc_pkg::COORD_BITS;
  localparam int COORD_MIN     = -(1 <<< (CW - 1));
  localparam int COORD_MAX     = (1 <<< (CW - 1)) - 1;
  localparam int COORD_SPAN    = (1 <<< CW) - 1;
  localparam longint ONE_Q     = longint'(1) <<< rwlc_pkg::FRAC_BITS;
  localparam int DIRECTED_ROWS = 28;
  localparam int RANDOM_SEGS   = 630;
  localparam int DRAIN_CYCLES  = 600;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [CW-1:0] xs, ys, xe, ye;
  } segment_t;

  typedef struct packed {
    logic          vis;
    logic [CW-1:0] xs, ys, xe, ye;
  } clipped_t;

  typedef enum logic {ROW_WINDOW, ROW_SEGMENT} row_kind_e;

  typedef struct packed {
    row_kind_e     kind;
    logic [CW-1:0] a, b, c, d;  // endpoints, or xmin, xmax, ymin, ymax for a window row
    logic          typed;
    clipped_t      want;
  } plan_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [rwlc_pkg::CFG_IDX_BITS-1:0] cfg_index = rwlc_pkg::REG_XMIN;
  logic [CW-1:0]           cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [CW-1:0]    seg_x_start = '0;
  logic signed [CW-1:0]    seg_y_start = '0;
  logic signed [CW-1:0]    seg_x_end = '0;
  logic signed [CW-1:0]    seg_y_end = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    visible;
  logic signed [CW-1:0]    clip_x_start;
  logic signed [CW-1:0]    clip_y_start;
  logic signed [CW-1:0]    clip_x_end;
  logic signed [CW-1:0]    clip_y_end;

  logic [CW-1:0] win_reg [4] = '{16'd0, 16'd1023, 16'd0, 16'd767};
  logic [rwlc_pkg::CFG_IDX_BITS-1:0] reg_order [4] =
    '{rwlc_pkg::REG_XMIN, rwlc_pkg::REG_XMAX, rwlc_pkg::REG_YMIN, rwlc_pkg::REG_YMAX};
  clipped_t pending_clips [$];
  int       cycles = 0;
  int       n_bad = 0;
  bit       idle_on = 1'b1;
  bit       stall_on = 1'b1;

  plan_row_t plan [DIRECTED_ROWS] = '{
    '{ROW_SEGMENT, 0, 0, 1023, 767, 1'b1, '{1'b1, 0, 0, 1023, 767}},
    '{ROW_SEGMENT, 5, 5, 5, 5, 1'b1, '{1'b1, 5, 5, 5, 5}},
    '{ROW_SEGMENT, -32768, -32768, -32768, 32767, 1'b1, '0},
    '{ROW_SEGMENT, 32767, 32767, 32767, -32768, 1'b1, '0},
    '{ROW_SEGMENT, -32768, 32767, 32767, 32767, 1'b1, '0},
    '{ROW_SEGMENT, -32768, -32768, 32767, -32768, 1'b1, '0},
    '{ROW_SEGMENT, -100, 384, 2000, 384, 1'b1, '{1'b1, 0, 384, 1023, 384}},
    '{ROW_SEGMENT, 512, -50, 512, 900, 1'b1, '{1'b1, 512, 0, 512, 767}},
    '{ROW_SEGMENT, -32768, -32768, 32767, 32767, 1'b0, '0},
    '{ROW_SEGMENT, 32767, -32768, -32768, 32767, 1'b0, '0},
    '{ROW_SEGMENT, -10, 800, 1100, -20, 1'b0, '0},
    '{ROW_SEGMENT, -500, 700, 100, 900, 1'b0, '0},
    '{ROW_SEGMENT, 1023, 767, 1024, 768, 1'b0, '0},
    '{ROW_SEGMENT, -1, -1, 0, 0, 1'b0, '0},
    // whole coordinate range
    '{ROW_WINDOW, -32768, 32767, -32768, 32767, 1'b0, '0},
    '{ROW_SEGMENT, -32768, 32767, 32767, -32768, 1'b1, '{1'b1, -32768, 32767, 32767, -32768}},
    '{ROW_SEGMENT, -1, 0, 1, -1, 1'b1, '{1'b1, -1, 0, 1, -1}},
    // inverted windows reject everything
    '{ROW_WINDOW, 10, 5, 0, 767, 1'b0, '0},
    '{ROW_SEGMENT, 7, 100, 7, 100, 1'b1, '0},
    '{ROW_SEGMENT, -32768, -32768, 32767, 32767, 1'b1, '0},
    '{ROW_WINDOW, 0, 1023, 300, 200, 1'b0, '0},
    '{ROW_SEGMENT, 500, 250, 600, 250, 1'b1, '0},
    // single-point window
    '{ROW_WINDOW, 7, 7, -3, -3, 1'b0, '0},
    '{ROW_SEGMENT, 0, -10, 14, 4, 1'b0, '0},
    '{ROW_SEGMENT, 7, -3, 7, -3, 1'b1, '{1'b1, 7, -3, 7, -3}},
    '{ROW_WINDOW, -2000, -1000, -1500, -200, 1'b0, '0},
    '{ROW_SEGMENT, -32768, 0, 0, -32768, 1'b0, '0},
    '{ROW_SEGMENT, -1500, -800, -1200, -300, 1'b1, '{1'b1, -1500, -800, -1200, -300}}
  };

  rect_window_line_clipper u_top (.*);

  always #5 clk = ~clk;

  function automatic longint to_q(logic [CW-1:0] v);
    return longint'($signed(v)) * ONE_Q;
  endfunction

  function automatic logic [3:0] region_code(longint x, longint y, longint xl, longint xh,
                                             longint yl, longint yh);
    logic [3:0] c;
    c = '0;
    if (x < xl) c |= rwlc_pkg::OC_LEFT;
    else if (x > xh) c |= rwlc_pkg::OC_RIGHT;
    if (y < yl) c |= rwlc_pkg::OC_BOTTOM;
    else if (y > yh) c |= rwlc_pkg::OC_TOP;
    return c;
  endfunction

  // trunc(a * b / d) toward zero, wide product
  function automatic longint scaled_quot(longint a, longint b, longint d);
    logic [127:0] prod, quot;
    logic [63:0]  ua, ub, ud;
    bit           neg;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    ud = (d < 0) ? -d : d;
    neg = ((a < 0) != (b < 0)) != (d < 0);
    if (ud == 0) return 0;
    prod = 128'(ua) * 128'(ub);
    quot = prod / 128'(ud);
    quot[127:62] = '0;
    return neg ? -longint'(quot[63:0]) : longint'(quot[63:0]);
  endfunction

  function automatic clipped_t clip_segment(segment_t s);
    longint     xl, xh, yl, yh, x1, y1, x2, y2, x, y;
    logic [3:0] c1, c2, c;
    clipped_t   r;
    r = '0;
    if ($signed(win_reg[rwlc_pkg::REG_XMIN]) > $signed(win_reg[rwlc_pkg::REG_XMAX]) ||
        $signed(win_reg[rwlc_pkg::REG_YMIN]) > $signed(win_reg[rwlc_pkg::REG_YMAX]))
      return r;
    xl = to_q(win_reg[rwlc_pkg::REG_XMIN]);
    xh = to_q(win_reg[rwlc_pkg::REG_XMAX]);
    yl = to_q(win_reg[rwlc_pkg::REG_YMIN]);
    yh = to_q(win_reg[rwlc_pkg::REG_YMAX]);
    x1 = to_q(s.xs);
    y1 = to_q(s.ys);
    x2 = to_q(s.xe);
    y2 = to_q(s.ye);
    c1 = region_code(x1, y1, xl, xh, yl, yh);
    c2 = region_code(x2, y2, xl, xh, yl, yh);
    for (int pass = 0; pass <= rwlc_pkg::MAX_PASSES; pass++) begin
      if (c1 == 0 && c2 == 0) begin
        r.vis = 1'b1;
        r.xs  = CW'(x1 / ONE_Q);
        r.ys  = CW'(y1 / ONE_Q);
        r.xe  = CW'(x2 / ONE_Q);
        r.ye  = CW'(y2 / ONE_Q);
        return r;
      end
      if ((c1 & c2) != 0 || pass == rwlc_pkg::MAX_PASSES)
        return r;
      c = (c1 != 0) ? c1 : c2;
      // edge priority: top, bottom, right, left
      if ((c & rwlc_pkg::OC_TOP) != 0) begin
        x = x1 + scaled_quot(x2 - x1, yh - y1, y2 - y1);
        y = yh;
      end else if ((c & rwlc_pkg::OC_BOTTOM) != 0) begin
        x = x1 + scaled_quot(x2 - x1, yl - y1, y2 - y1);
        y = yl;
      end else if ((c & rwlc_pkg::OC_RIGHT) != 0) begin
        y = y1 + scaled_quot(y2 - y1, xh - x1, x2 - x1);
        x = xh;
      end else begin
        y = y1 + scaled_quot(y2 - y1, xl - x1, x2 - x1);
        x = xl;
      end
      if (c1 != 0) begin
        x1 = x;
        y1 = y;
        c1 = region_code(x1, y1, xl, xh, yl, yh);
      end else begin
        x2 = x;
        y2 = y;
        c2 = region_code(x2, y2, xl, xh, yl, yh);
      end
    end
    return r;
  endfunction

  function automatic int gap_len(bit enable);
    int r;
    if (!enable) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // mostly inside the window or close to its edges
  function automatic logic [CW-1:0] pick_coord(int lo, int hi);
    int a, b, v;
    a = (lo < hi) ? lo : hi;
    b = (lo < hi) ? hi : lo;
    case ($urandom_range(0, 9))
      0: v = COORD_MIN + int'($urandom_range(0, COORD_SPAN));
      1: v = $urandom_range(0, 1) ? COORD_MIN : COORD_MAX;
      2, 3, 4: v = a + int'($urandom_range(0, b - a));
      default: v = ($urandom_range(0, 1) ? a : b) + int'($urandom_range(0, 128)) - 64;
    endcase
    if (v < COORD_MIN) v = COORD_MIN;
    if (v > COORD_MAX) v = COORD_MAX;
    return CW'(v);
  endfunction

  task automatic choose_window(output int xmin, output int xmax, output int ymin,
                               output int ymax);
    int w, h;
    w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, COORD_SPAN) : $urandom_range(1, 2000);
    h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, COORD_SPAN) : $urandom_range(1, 2000);
    xmin = COORD_MIN + int'($urandom_range(0, COORD_SPAN - w));
    xmax = xmin + w;
    ymin = COORD_MIN + int'($urandom_range(0, COORD_SPAN - h));
    ymax = ymin + h;
    case ($urandom_range(0, 9))
      0: begin
        xmin = COORD_MIN;
        xmax = COORD_MAX;
        ymin = COORD_MIN;
        ymax = COORD_MAX;
      end
      1: {xmin, xmax} = {xmax, xmin};
      2: {ymin, ymax} = {ymax, ymin};
      3: xmax = xmin;
      4: ymax = ymin;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (pending_clips.size() != 0);
  endtask

  task automatic program_window(input int xmin, input int xmax, input int ymin,
                                input int ymax);
    logic [CW-1:0] vals [4];
    vals[rwlc_pkg::REG_XMIN] = CW'(xmin);
    vals[rwlc_pkg::REG_XMAX] = CW'(xmax);
    vals[rwlc_pkg::REG_YMIN] = CW'(ymin);
    vals[rwlc_pkg::REG_YMAX] = CW'(ymax);
    cfg_valid <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_index <= reg_order[i];
      cfg_data  <= vals[reg_order[i]];
      do @(posedge clk); while (!cfg_ready);
      win_reg[reg_order[i]] = vals[reg_order[i]];
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_seg(input segment_t s, input logic typed, input clipped_t typed_want,
                          input bit last);
    int       gap;
    clipped_t expect_clip;
    seg_x_start <= s.xs;
    seg_y_start <= s.ys;
    seg_x_end   <= s.xe;
    seg_y_end   <= s.ye;
    in_valid    <= 1'b1;
    do @(posedge clk); while (!in_ready);
    expect_clip = typed ? typed_want : clip_segment(s);
    pending_clips = {pending_clips, expect_clip};
    gap = gap_len(idle_on);
    // drop valid before the window changes
    if (last && gap == 0) gap = 1;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic flag_error(input string msg);
    n_bad++;
    if (n_bad <= REPORT_LIMIT) $display("ERROR cycle %0d: %s", cycles, msg);
  endtask

  task automatic check_field(input string name, input logic [CW-1:0] want_v,
                             input logic [CW-1:0] got_v);
    if (got_v !== want_v)
      flag_error($sformatf("%s expected %0d, got %0d", name, $signed(want_v), $signed(got_v)));
  endtask

  always @(posedge clk) begin : check_results
    clipped_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_clips.size() == 0) begin
        flag_error("output transaction with no segment pending");
      end else begin
        want = pending_clips.pop_front();
        check_field("visible", CW'(want.vis), CW'(visible));
        check_field("clip_x_start", want.xs, clip_x_start);
        check_field("clip_y_start", want.ys, clip_y_start);
        check_field("clip_x_end", want.xe, clip_x_end);
        check_field("clip_y_end", want.ye, clip_y_end);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("rect_window_line_clipper: mismatch");
      $finish;
    end
  end

  initial begin : result_sink
    int n;
    do @(posedge clk); while (rst);
    forever begin
      n = gap_len(stall_on);
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  initial begin : stimulus
    int       xmin, xmax, ymin, ymax, n, sent;
    bit       last;
    segment_t s;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (plan[i].kind == ROW_WINDOW) begin
        wait_idle();
        program_window(int'($signed(plan[i].a)), int'($signed(plan[i].b)),
                       int'($signed(plan[i].c)), int'($signed(plan[i].d)));
      end else begin
        last = (i == DIRECTED_ROWS - 1) || (plan[i + 1].kind == ROW_WINDOW);
        send_seg({plan[i].a, plan[i].b, plan[i].c, plan[i].d}, plan[i].typed, plan[i].want,
                 last);
      end
    end

    sent = 0;
    while (sent < RANDOM_SEGS) begin
      choose_window(xmin, xmax, ymin, ymax);
      wait_idle();
      program_window(xmin, xmax, ymin, ymax);
      idle_on  = $urandom_range(0, 3) != 0;
      stall_on = $urandom_range(0, 3) != 0;
      n = $urandom_range(20, 70);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          s = segment_t'({$urandom, $urandom});
        end else begin
          s.xs = pick_coord(xmin, xmax);
          s.ys = pick_coord(ymin, ymax);
          s.xe = pick_coord(xmin, xmax);
          s.ye = pick_coord(ymin, ymax);
        end
        send_seg(s, 1'b0, '0, k == n - 1);
      end
      sent += n;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_bad == 0 && pending_clips.size() == 0)
      $display("rect_window_line_clipper: match");
    else
      $display("rect_window_line_clipper: mismatch");
    $finish;
  end

endmodule
